@@ src/crtd_pkg.sv @@
`timescale 1ns / 1ps

package crtd_pkg;

    localparam int ROW_CHARS   = 40;
    localparam int TAB_STEP    = 8;
    localparam int MAX_CELLS   = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int CLR_W  = 3;
    localparam int TAB_W  = $clog2(TAB_STEP + 1);
    localparam int CNT_W  = $clog2(MAX_CELLS);
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = 5'd30;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] INV_MASK = 8'h80;
    localparam logic [7:0] ALPHA_OFS = 8'h37;

    localparam logic [CLR_W-1:0] CLR_GRAY   = 3'd0;
    localparam logic [CLR_W-1:0] CLR_WHITE  = 3'd1;
    localparam logic [CLR_W-1:0] CLR_GREEN  = 3'd2;
    localparam logic [CLR_W-1:0] CLR_YELLOW = 3'd3;
    localparam logic [CLR_W-1:0] CLR_RED    = 3'd4;

    // class of a byte in plain text
    localparam logic [2:0] NC_DROP  = 3'd0;
    localparam logic [2:0] NC_EOL   = 3'd1;
    localparam logic [2:0] NC_TAB   = 3'd2;
    localparam logic [2:0] NC_CARET = 3'd3;
    localparam logic [2:0] NC_CHAR  = 3'd4;

    // meaning of a byte after a caret
    localparam logic [2:0] CK_COLOUR  = 3'd0;
    localparam logic [2:0] CK_CODE    = 3'd1;
    localparam logic [2:0] CK_INV_ON  = 3'd2;
    localparam logic [2:0] CK_INV_OFF = 3'd3;
    localparam logic [2:0] CK_LIT     = 3'd4;

    localparam logic [1:0] REG_ROW_LIMIT = 2'd0;

    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]       char_code;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [CLR_W-1:0] colour;
        logic             last;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [2:0] cls;
        logic [2:0] ckind;
        logic [7:0] cval;
        logic [7:0] text_byte;
    } t_cmd;

endpackage

@@ src/crtd_front.sv @@
`timescale 1ns / 1ps

module crtd_front (
    input  logic           i_in_valid,
    input  crtd_pkg::t_in  i_in_data,
    input  logic           i_q_full,
    output logic           o_in_ready,
    output logic           o_push,
    output crtd_pkg::t_cmd o_cmd
);
    import crtd_pkg::*;

    logic [7:0] b;

    assign b          = i_in_data.text_byte;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.start     = i_in_data.req_type;
        o_cmd.text_byte = b;

        unique case (b) inside
            CH_CR:          o_cmd.cls = NC_DROP;
            CH_LF, CH_NUL:  o_cmd.cls = NC_EOL;
            CH_TAB:         o_cmd.cls = NC_TAB;
            CH_CARET:       o_cmd.cls = NC_CARET;
            default:        o_cmd.cls = NC_CHAR;
        endcase

        // both readings are prepared, the back end picks by its mode
        o_cmd.cval = b;
        unique case (b) inside
            CH_ZERO: begin
                o_cmd.ckind = CK_COLOUR;
                o_cmd.cval  = {5'd0, CLR_GRAY};
            end
            CH_W: begin
                o_cmd.ckind = CK_COLOUR;
                o_cmd.cval  = {5'd0, CLR_WHITE};
            end
            CH_X: begin
                o_cmd.ckind = CK_COLOUR;
                o_cmd.cval  = {5'd0, CLR_GREEN};
            end
            CH_Y: begin
                o_cmd.ckind = CK_COLOUR;
                o_cmd.cval  = {5'd0, CLR_YELLOW};
            end
            CH_Z: begin
                o_cmd.ckind = CK_COLOUR;
                o_cmd.cval  = {5'd0, CLR_RED};
            end
            [CH_ONE:CH_NINE]: begin
                o_cmd.ckind = CK_CODE;
                o_cmd.cval  = b - CH_ZERO;
            end
            [CH_A:CH_V]: begin
                o_cmd.ckind = CK_CODE;
                o_cmd.cval  = b - ALPHA_OFS;
            end
            CH_LBRK:  o_cmd.ckind = CK_INV_ON;
            CH_RBRK:  o_cmd.ckind = CK_INV_OFF;
            default:  o_cmd.ckind = CK_LIT;
        endcase
    end

endmodule

@@ src/crtd_queue.sv @@
`timescale 1ns / 1ps

module crtd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  crtd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output crtd_pkg::t_cmd o_cmd
);
    import crtd_pkg::*;

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    logic            do_pop;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/crtd_back.sv @@
`timescale 1ns / 1ps

module crtd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  crtd_pkg::t_cmd         i_cmd,
    input  logic [crtd_pkg::ROW_W-1:0] i_row_limit,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output crtd_pkg::t_out         o_out_data,
    input  logic                   i_out_ready
);
    import crtd_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CARET  = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;
    localparam logic [1:0] MODE_IDLE   = 2'd3;

    logic [1:0]       r_mode,   n_mode;
    logic [COL_W-1:0] r_col,    n_col;
    logic [ROW_W-1:0] r_row,    n_row;
    logic [CLR_W-1:0] r_colour, n_colour;
    logic             r_inv,    n_inv;
    logic [TAB_W-1:0] r_phase,  n_phase;
    logic [CNT_W-1:0] r_tab_n,  n_tab_n;
    logic             r_out_valid;
    t_out             r_out;

    logic             can_emit;
    logic             emit;
    logic [7:0]       emit_code;
    logic             emit_last;
    logic [COL_W-1:0] col_inc;
    logic [TAB_W-1:0] phase_inc;
    logic [TAB_W-1:0] phase_next;
    logic [ROW_W-1:0] row_inc;
    logic             tab_more;
    t_out             out_cell;

    assign can_emit   = !r_out_valid || i_out_ready;
    assign col_inc    = r_col + 1'b1;
    assign phase_inc  = r_phase + 1'b1;
    assign phase_next = (phase_inc == TAB_W'(TAB_STEP)) ? '0 : phase_inc;
    assign row_inc    = r_row + 1'b1;
    // a tab goes on while the cell budget, the row and the tab stop allow
    assign tab_more   = (r_tab_n != CNT_W'(MAX_CELLS - 1)) &&
                        (col_inc < COL_W'(ROW_CHARS)) && (phase_next != '0);

    always_comb begin
        n_mode    = r_mode;
        n_col     = r_col;
        n_row     = r_row;
        n_colour  = r_colour;
        n_inv     = r_inv;
        n_phase   = r_phase;
        n_tab_n   = r_tab_n;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_code = i_cmd.text_byte;
        emit_last = 1'b1;

        if (i_cmd_valid) begin
            if (i_cmd.start) begin
                n_mode   = MODE_NORMAL;
                n_col    = '0;
                n_row    = '0;
                n_colour = CLR_GRAY;
                n_inv    = 1'b0;
                n_phase  = '0;
                n_tab_n  = '0;
                o_pop    = 1'b1;
            end else if (r_mode == MODE_IDLE || i_cmd.cls == NC_DROP) begin
                o_pop = 1'b1;
            end else if (i_cmd.cls == NC_EOL) begin
                n_row    = row_inc;
                n_col    = '0;
                n_phase  = '0;
                n_colour = CLR_GRAY;
                n_inv    = 1'b0;
                n_mode   = (row_inc >= i_row_limit) ? MODE_IDLE : MODE_NORMAL;
                o_pop    = 1'b1;
            end else if (r_mode == MODE_SKIP) begin
                o_pop = 1'b1;
            end else if (r_mode == MODE_CARET) begin
                case (i_cmd.ckind)
                    CK_COLOUR: begin
                        n_colour = i_cmd.cval[CLR_W-1:0];
                        n_mode   = MODE_NORMAL;
                        o_pop    = 1'b1;
                    end
                    CK_INV_ON: begin
                        n_inv  = 1'b1;
                        n_mode = MODE_NORMAL;
                        o_pop  = 1'b1;
                    end
                    CK_INV_OFF: begin
                        n_inv  = 1'b0;
                        n_mode = MODE_NORMAL;
                        o_pop  = 1'b1;
                    end
                    default: begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            emit_code = (i_cmd.ckind == CK_CODE) ? i_cmd.cval
                                                                 : i_cmd.text_byte;
                            n_mode    = MODE_NORMAL;
                            o_pop     = 1'b1;
                        end
                    end
                endcase
            end else begin
                case (i_cmd.cls)
                    NC_CARET: begin
                        n_mode = MODE_CARET;
                        o_pop  = 1'b1;
                    end
                    NC_TAB: begin
                        if (can_emit) begin
                            emit      = 1'b1;
                            emit_code = CH_SPACE;
                            emit_last = !tab_more;
                            o_pop     = !tab_more;
                            n_tab_n   = tab_more ? r_tab_n + 1'b1 : '0;
                        end
                    end
                    default: begin
                        if (can_emit) begin
                            emit  = 1'b1;
                            o_pop = 1'b1;
                        end
                    end
                endcase
            end

            if (emit) begin
                n_col   = col_inc;
                n_phase = phase_next;
                if (col_inc >= COL_W'(ROW_CHARS)) begin
                    n_mode = MODE_SKIP;
                end
            end
        end
    end

    always_comb begin
        out_cell.char_code = emit_code ^ (r_inv ? INV_MASK : 8'h00);
        out_cell.column    = r_col;
        out_cell.row       = r_row;
        out_cell.colour    = r_colour;
        out_cell.last      = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_col       <= '0;
            r_row       <= '0;
            r_colour    <= CLR_GRAY;
            r_inv       <= 1'b0;
            r_phase     <= '0;
            r_tab_n     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_col    <= n_col;
            r_row    <= n_row;
            r_colour <= n_colour;
            r_inv    <= n_inv;
            r_phase  <= n_phase;
            r_tab_n  <= n_tab_n;
            if (can_emit) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= out_cell;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/caret_markup_text_row_decoder_unit.sv @@
`timescale 1ns / 1ps
// caret markup text row decoder
// input channel: one request per text byte (req_type 0) or a start request
// (req_type 1) that clears position, colour, invert and mode; row_limit stays
// output: one cell per request, one or more per tab; last marks the final cell
// of a request; carriage returns, escape prefixes, colour and invert changes,
// row ends, start requests and skipped bytes give no cell
// a front stage classifies each byte and writes it into a four entry queue,
// a back stage holds the decode state and fills the output register
// the queue holds each accepted byte until the back stage registers its cell
// throughput: one request per cycle while the queue is not full; a tab holds
// the back stage for its spaces, up to eight, while the queue keeps taking bytes
// a stalled receiver holds the output register; the back stage stops and the
// queue fills, then ready drops
// reset clears the decode state and the queue and sets row_limit to 30;
// no clearing pass is needed
// apb: row_limit at byte address 0; the user writes it during idle only, unenforced
module caret_markup_text_row_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  crtd_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output crtd_pkg::t_out                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crtd_pkg::APB_AW-1:0]   paddr,
    input  logic [crtd_pkg::APB_DW-1:0]   pwdata,
    output logic [crtd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import crtd_pkg::*;

    logic [ROW_W-1:0] r_row_limit;
    logic             reg_hit;
    logic             q_full;
    logic             push;
    t_cmd             push_cmd;
    logic             head_valid;
    t_cmd             head_cmd;
    logic             pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_ROW_LIMIT[0]);
    assign prdata  = reg_hit ? {{(APB_DW - ROW_W){1'b0}}, r_row_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit <= ROW_LIMIT_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_row_limit <= pwdata[ROW_W-1:0];
        end
    end

    crtd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    crtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    crtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .i_row_limit (r_row_limit),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

@@ src/crtd_checker.sv @@
`timescale 1ns / 1ps

module crtd_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  crtd_pkg::t_out o_out_data,
    input  logic           pready
);
    import crtd_pkg::*;

    // a held cell keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output cell changed while stalled");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.column < COL_W'(ROW_CHARS))
        else $error("column beyond row width");

    // only tabs give more than one cell per request
    a_multi_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.char_code[6:0] == CH_SPACE[6:0])
        else $error("non-final cell is not a space");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind caret_markup_text_row_decoder_unit crtd_checker u_crtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
